>>> design/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared command codes and flag bundle for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef struct packed {
        logic is_div;
        logic dz;
        logic neg_r;
        logic neg_i;
        logic qovf_r;
        logic qovf_i;
    } flags_t;

endpackage

>>> design/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex add, subtract, multiply and divide in signed fixed point.
// ----------------------------------------------------------------------------
// Input transfers on s_*: command and two complex operands a and b, each part
// DATA_WIDTH bits with FRAC_BITS fraction bits. Each input produces exactly one
// result transfer on m_*: both result parts plus divide_by_zero and overflow.
// Throughput: one item per cycle while m_tready is high; every stage is a register with its own valid.
// Stages in order: operand register, products, sums, divider setup, one stage
// per quotient bit (DATA_WIDTH + 1, a restoring divider step each), and the
// output register. All commands take the same path, so results leave in
// input order.
// Multiply shifts the exact sum of products right (toward negative infinity);
// divide truncates toward zero; out-of-range parts saturate and set overflow.
// A zero divisor gives zero parts with divide_by_zero set.
// Reset clears all valid bits; no result is pending afterward.
// When m_tready is low the output holds and stages fill from the back; the
// block keeps taking input until the bubble space is used, then drops
// s_tready. Nothing is lost or repeated across a stall.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit import cau_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // command, a_real, a_imag, b_real, b_imag (low to high), zero padded
    input  logic [((2+4*DATA_WIDTH+7)/8)*8-1:0]         s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // result_real, result_imag, divide_by_zero, overflow (low to high), zero padded
    output logic [((2+2*DATA_WIDTH+7)/8)*8-1:0]         m_tdata
);
    localparam int W   = DATA_WIDTH;
    localparam int QB  = DATA_WIDTH + 1;
    localparam int CW  = 2*DATA_WIDTH + FRAC_BITS + QB;
    localparam int OW  = ((2+2*DATA_WIDTH+7)/8)*8;

    logic            dv    [QB+1];
    logic            drdy  [QB+1];
    flags_t          dflg  [QB+1];
    logic [2*W-1:0]  dden  [QB+1];
    logic [CW-1:0]   dremr [QB+1];
    logic [CW-1:0]   dremi [QB+1];
    logic [QB-1:0]   dquor [QB+1];
    logic [QB-1:0]   dquoi [QB+1];

    logic [W-1:0] res_r, res_i;
    logic         res_dz, res_ovf;

    cau_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (cmd_t'(s_tdata[1:0])),
        .in_ar     (s_tdata[2+W-1:2]),
        .in_ai     (s_tdata[2+2*W-1:2+W]),
        .in_br     (s_tdata[2+3*W-1:2+2*W]),
        .in_bi     (s_tdata[2+4*W-1:2+3*W]),
        .out_valid (dv[0]),
        .out_ready (drdy[0]),
        .out_flags (dflg[0]),
        .out_den   (dden[0]),
        .out_rem_r (dremr[0]),
        .out_rem_i (dremi[0])
    );
    assign dquor[0] = '0;
    assign dquoi[0] = '0;

    // quotient bits resolved from the top down
    for (genvar k = 0; k < QB; k++) begin : g_div
        cau_div_stage #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS),
            .SHIFT      (QB-1-k)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (dv[k]),
            .in_ready  (drdy[k]),
            .in_flags  (dflg[k]),
            .in_den    (dden[k]),
            .in_rem_r  (dremr[k]),
            .in_rem_i  (dremi[k]),
            .in_quo_r  (dquor[k]),
            .in_quo_i  (dquoi[k]),
            .out_valid (dv[k+1]),
            .out_ready (drdy[k+1]),
            .out_flags (dflg[k+1]),
            .out_den   (dden[k+1]),
            .out_rem_r (dremr[k+1]),
            .out_rem_i (dremi[k+1]),
            .out_quo_r (dquor[k+1]),
            .out_quo_i (dquoi[k+1])
        );
    end

    cau_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dv[QB]),
        .in_ready  (drdy[QB]),
        .in_flags  (dflg[QB]),
        .in_rem_r  (dremr[QB]),
        .in_rem_i  (dremi[QB]),
        .in_quo_r  (dquor[QB]),
        .in_quo_i  (dquoi[QB]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_real  (res_r),
        .out_imag  (res_i),
        .out_dz    (res_dz),
        .out_ovf   (res_ovf)
    );

    assign m_tdata = OW'({res_ovf, res_dz, res_i, res_r});

    logic unused_den;
    assign unused_den = ^dden[QB];

endmodule

>>> design/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Operand register, product stage, sum stage and divider setup stage.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  cmd_t                                        in_cmd,
    input  logic signed [DATA_WIDTH-1:0]                in_ar,
    input  logic signed [DATA_WIDTH-1:0]                in_ai,
    input  logic signed [DATA_WIDTH-1:0]                in_br,
    input  logic signed [DATA_WIDTH-1:0]                in_bi,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output flags_t                                      out_flags,
    output logic [2*DATA_WIDTH-1:0]                     out_den,
    output logic [3*DATA_WIDTH+FRAC_BITS:0]             out_rem_r,
    output logic [3*DATA_WIDTH+FRAC_BITS:0]             out_rem_i
);
    localparam int W  = DATA_WIDTH;
    localparam int QB = DATA_WIDTH + 1;
    localparam int CW = 2*DATA_WIDTH + FRAC_BITS + QB;

    // operand register
    logic                v1_reg;
    cmd_t                cmd1_reg;
    logic signed [W-1:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;
    // products
    logic                  v2_reg;
    cmd_t                  cmd2_reg;
    logic signed [2*W-1:0] prr_reg, pii_reg, pri_reg, pir_reg, pbb_reg, pcc_reg;
    logic signed [W:0]     asr_reg, asi_reg;
    // sums
    logic                v3_reg;
    cmd_t                cmd3_reg;
    logic signed [2*W:0] sr_reg, si_reg;
    logic [2*W-1:0]      den3_reg;
    // divider setup
    logic                v4_reg;
    flags_t              flags4_reg;
    logic [2*W-1:0]      den4_reg;
    logic [CW-1:0]       remr4_reg, remi4_reg;

    logic rdy1, rdy2, rdy3, rdy4;
    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    logic signed [W:0]     asr_next, asi_next;
    logic signed [2*W:0]   sr_next, si_next;
    logic [2*W-1:0]        den3_next;
    flags_t                flags4_next;
    logic [CW-1:0]         remr4_next, remi4_next;
    logic [2*W-1:0]        magr, magi;
    logic signed [2*W:0]   shr, shi, negr_v, negi_v;
    logic [CW-1:0]         mr, mi, dsh;

    always_comb begin
        if (cmd1_reg == CMD_SUB) begin
            asr_next = {ar1_reg[W-1], ar1_reg} - {br1_reg[W-1], br1_reg};
            asi_next = {ai1_reg[W-1], ai1_reg} - {bi1_reg[W-1], bi1_reg};
        end else begin
            asr_next = {ar1_reg[W-1], ar1_reg} + {br1_reg[W-1], br1_reg};
            asi_next = {ai1_reg[W-1], ai1_reg} + {bi1_reg[W-1], bi1_reg};
        end
    end

    always_comb begin
        den3_next = pbb_reg[2*W-1:0] + pcc_reg[2*W-1:0];
        unique case (cmd2_reg)
            CMD_MUL: begin
                sr_next = {prr_reg[2*W-1], prr_reg} - {pii_reg[2*W-1], pii_reg};
                si_next = {pri_reg[2*W-1], pri_reg} + {pir_reg[2*W-1], pir_reg};
            end
            CMD_DIV: begin
                sr_next = {prr_reg[2*W-1], prr_reg} + {pii_reg[2*W-1], pii_reg};
                si_next = {pir_reg[2*W-1], pir_reg} - {pri_reg[2*W-1], pri_reg};
            end
            default: begin
                sr_next = {{(W){asr_reg[W]}}, asr_reg};
                si_next = {{(W){asi_reg[W]}}, asi_reg};
            end
        endcase
    end

    always_comb begin
        negr_v = -sr_reg;
        negi_v = -si_reg;
        magr   = sr_reg[2*W] ? negr_v[2*W-1:0] : sr_reg[2*W-1:0];
        magi   = si_reg[2*W] ? negi_v[2*W-1:0] : si_reg[2*W-1:0];
        mr     = CW'(magr) << FRAC_BITS;
        mi     = CW'(magi) << FRAC_BITS;
        dsh    = CW'(den3_reg) << QB;
        shr    = sr_reg >>> FRAC_BITS;
        shi    = si_reg >>> FRAC_BITS;

        flags4_next.is_div = (cmd3_reg == CMD_DIV);
        flags4_next.dz     = (cmd3_reg == CMD_DIV) && (den3_reg == '0);
        flags4_next.neg_r  = sr_reg[2*W];
        flags4_next.neg_i  = si_reg[2*W];
        flags4_next.qovf_r = (mr >= dsh);
        flags4_next.qovf_i = (mi >= dsh);
        unique case (cmd3_reg)
            CMD_DIV: begin
                remr4_next = mr;
                remi4_next = mi;
            end
            CMD_MUL: begin
                remr4_next = {{(CW-2*W-1){shr[2*W]}}, shr};
                remi4_next = {{(CW-2*W-1){shi[2*W]}}, shi};
            end
            default: begin
                remr4_next = {{(CW-2*W-1){sr_reg[2*W]}}, sr_reg};
                remi4_next = {{(CW-2*W-1){si_reg[2*W]}}, si_reg};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            cmd1_reg <= in_cmd;
            ar1_reg  <= in_ar;
            ai1_reg  <= in_ai;
            br1_reg  <= in_br;
            bi1_reg  <= in_bi;
        end
        if (rdy2) begin
            cmd2_reg <= cmd1_reg;
            prr_reg  <= ar1_reg * br1_reg;
            pii_reg  <= ai1_reg * bi1_reg;
            pri_reg  <= ar1_reg * bi1_reg;
            pir_reg  <= ai1_reg * br1_reg;
            pbb_reg  <= br1_reg * br1_reg;
            pcc_reg  <= bi1_reg * bi1_reg;
            asr_reg  <= asr_next;
            asi_reg  <= asi_next;
        end
        if (rdy3) begin
            cmd3_reg <= cmd2_reg;
            sr_reg   <= sr_next;
            si_reg   <= si_next;
            den3_reg <= den3_next;
        end
        if (rdy4) begin
            flags4_reg <= flags4_next;
            den4_reg   <= den3_reg;
            remr4_reg  <= remr4_next;
            remi4_reg  <= remi4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_flags = flags4_reg;
    assign out_den   = den4_reg;
    assign out_rem_r = remr4_reg;
    assign out_rem_i = remi4_reg;

endmodule

>>> design/cau_div_stage.sv
// ----------------------------------------------------------------------------
// cau_div_stage
// One restoring division step for both parts: resolves quotient bit SHIFT.
// ----------------------------------------------------------------------------
module cau_div_stage import cau_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int SHIFT      = 0
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  flags_t                               in_flags,
    input  logic [2*DATA_WIDTH-1:0]              in_den,
    input  logic [3*DATA_WIDTH+FRAC_BITS:0]      in_rem_r,
    input  logic [3*DATA_WIDTH+FRAC_BITS:0]      in_rem_i,
    input  logic [DATA_WIDTH:0]                  in_quo_r,
    input  logic [DATA_WIDTH:0]                  in_quo_i,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output flags_t                               out_flags,
    output logic [2*DATA_WIDTH-1:0]              out_den,
    output logic [3*DATA_WIDTH+FRAC_BITS:0]      out_rem_r,
    output logic [3*DATA_WIDTH+FRAC_BITS:0]      out_rem_i,
    output logic [DATA_WIDTH:0]                  out_quo_r,
    output logic [DATA_WIDTH:0]                  out_quo_i
);
    localparam int QB = DATA_WIDTH + 1;
    localparam int CW = 2*DATA_WIDTH + FRAC_BITS + QB;

    logic            v_reg;
    flags_t          flags_reg;
    logic [2*DATA_WIDTH-1:0] den_reg;
    logic [CW-1:0]   remr_reg, remi_reg, remr_next, remi_next, dsh;
    logic [QB-1:0]   quor_reg, quoi_reg, quor_next, quoi_next;
    logic            active;

    assign in_ready = !v_reg || out_ready;

    always_comb begin
        dsh       = CW'(in_den) << SHIFT;
        active    = in_flags.is_div && !in_flags.dz;
        remr_next = in_rem_r;
        remi_next = in_rem_i;
        quor_next = in_quo_r;
        quoi_next = in_quo_i;
        // non-divide items carry their result in the remainder field untouched
        if (active && in_rem_r >= dsh) begin
            remr_next = in_rem_r - dsh;
            quor_next = in_quo_r | (QB'(1) << SHIFT);
        end
        if (active && in_rem_i >= dsh) begin
            remi_next = in_rem_i - dsh;
            quoi_next = in_quo_i | (QB'(1) << SHIFT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            flags_reg <= in_flags;
            den_reg   <= in_den;
            remr_reg  <= remr_next;
            remi_reg  <= remi_next;
            quor_reg  <= quor_next;
            quoi_reg  <= quoi_next;
        end
    end

    assign out_valid = v_reg;
    assign out_flags = flags_reg;
    assign out_den   = den_reg;
    assign out_rem_r = remr_reg;
    assign out_rem_i = remi_reg;
    assign out_quo_r = quor_reg;
    assign out_quo_i = quoi_reg;

endmodule

>>> design/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back
// Result selection, saturation and output register.
// ----------------------------------------------------------------------------
module cau_back import cau_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  flags_t                            in_flags,
    input  logic [3*DATA_WIDTH+FRAC_BITS:0]   in_rem_r,
    input  logic [3*DATA_WIDTH+FRAC_BITS:0]   in_rem_i,
    input  logic [DATA_WIDTH:0]               in_quo_r,
    input  logic [DATA_WIDTH:0]               in_quo_i,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [DATA_WIDTH-1:0]             out_real,
    output logic [DATA_WIDTH-1:0]             out_imag,
    output logic                              out_dz,
    output logic                              out_ovf
);
    localparam int W  = DATA_WIDTH;
    localparam int QB = DATA_WIDTH + 1;

    logic          v_reg, dz_reg, ovf_reg;
    logic [W-1:0]  re_reg, im_reg;
    logic [W-1:0]  re_next, im_next;
    logic          ovr, ovi;

    assign in_ready = !v_reg || out_ready;

    function automatic logic [W:0] saturate(input logic [2*W:0] v);
        logic [W-1:0] mx, mn;
        mx = {1'b0, {(W-1){1'b1}}};
        mn = {1'b1, {(W-1){1'b0}}};
        if (v[2*W:W-1] == '0 || v[2*W:W-1] == '1) begin
            saturate = {1'b0, v[W-1:0]};
        end else begin
            saturate = {1'b1, v[2*W] ? mn : mx};
        end
    endfunction

    function automatic logic [W:0] part(input logic [3*W+FRAC_BITS:0] rem,
                                       input logic [QB-1:0] quo,
                                       input logic neg, input logic qovf,
                                       input flags_t f);
        logic [QB:0]  sq;
        logic [2*W:0] v;
        sq = neg ? -{1'b0, quo} : {1'b0, quo};
        v  = {{(2*W-QB){sq[QB]}}, sq};
        if (!f.is_div) begin
            part = saturate(rem[2*W:0]);
        end else if (f.dz) begin
            part = '0;
        end else if (qovf) begin
            part = {1'b1, neg, {(W-1){!neg}}};
        end else begin
            part = saturate(v);
        end
    endfunction

    always_comb begin
        {ovr, re_next} = part(in_rem_r, in_quo_r, in_flags.neg_r, in_flags.qovf_r, in_flags);
        {ovi, im_next} = part(in_rem_i, in_quo_i, in_flags.neg_i, in_flags.qovf_i, in_flags);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            re_reg  <= re_next;
            im_reg  <= im_next;
            dz_reg  <= in_flags.dz;
            ovf_reg <= ovr || ovi;
        end
    end

    assign out_valid = v_reg;
    assign out_real  = re_reg;
    assign out_imag  = im_reg;
    assign out_dz    = dz_reg;
    assign out_ovf   = ovf_reg;

endmodule
